// File: design/ebb_pkg.sv
`default_nettype none
package ebb_pkg;

    // sizing
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int MAX_FIELD_BITS   = 32;
    localparam int SIZE_W           = 13;
    localparam int START_W          = 15;
    localparam int CURSOR_W         = 16;
    localparam int RES_W            = 33;
    localparam int PADDR_W          = 3;

    // register indexes
    localparam logic REG_BUFFER_SIZE = 1'b0;
    localparam logic REG_START_BIT   = 1'b1;

    // command codes
    typedef enum logic [3:0] {
        CMD_RESTART  = 4'd0,
        CMD_LOAD     = 4'd1,
        CMD_RD_BYTE  = 4'd2,
        CMD_WR_BITS  = 4'd3,
        CMD_WR_FLAG  = 4'd4,
        CMD_WR_UE    = 4'd5,
        CMD_RD_BITS  = 4'd6,
        CMD_RD_UE    = 4'd7,
        CMD_RD_SE    = 4'd8
    } t_cmd;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_FETCH,
        S_LZ,
        S_RDB,
        S_FIN
    } t_state;

    // bit engine phase
    typedef enum logic [1:0] {
        PH_WR,
        PH_RD,
        PH_PRE
    } t_phase;

endpackage
`default_nettype wire

// File: design/ebb_ram.sv
`default_nettype none
module ebb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  wire logic             i_clk;
    input  wire logic             i_we;
    input  wire logic [AW-1:0]    i_waddr;
    input  wire logic [WIDTH-1:0] i_wdata;
    input  wire logic [AW-1:0]    i_raddr;
    output logic      [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: design/exp_golomb_bit_buffer_core.sv
`default_nettype none
// Bit buffer with MSB-first cursor over a byte-wide single-read RAM.
// Restart and load go straight to S_FIN; read byte passes S_RDB, then S_FIN. Bit
// commands step bit by bit on the cached byte; a miss writes back a dirty byte
// and fetches the next one in S_FETCH. Write ue first scans leading zeros in S_LZ.
// One request in flight; the next is accepted when the result is registered.
// Synchronous active-low reset: cursor 0, buffer_size 4096, start_bit 0;
// RAM contents are not cleared.
module exp_golomb_bit_buffer_core #(
    parameter int BUFFER_BYTES = ebb_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [3:0]                      i_cmd,
    input  wire logic [11:0]                     i_addr,
    input  wire logic [5:0]                      i_count,
    input  wire logic [31:0]                     i_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [ebb_pkg::RES_W-1:0]     o_result_value,
    output logic                                 o_status,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ebb_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import ebb_pkg::*;

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(BUFFER_BYTES);

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    t_cmd                r_kind, n_kind;
    logic [CURSOR_W-1:0] r_cursor, n_cursor;
    logic [SIZE_W-1:0]   r_size;
    logic [START_W-1:0]  r_start;
    logic [6:0]          r_left, n_left;
    logic [RES_W-1:0]    r_wdata, n_wdata;
    logic [RES_W-1:0]    r_acc, n_acc;
    logic [4:0]          r_zeros, n_zeros;
    logic [7:0]          r_cache, n_cache;
    logic [AW-1:0]       r_caddr, n_caddr;
    logic                r_cok, n_cok;
    logic                r_dirty, n_dirty;
    logic [RES_W-1:0]    r_res, n_res;
    logic                r_err, n_err;
    logic                r_ovalid;
    logic [RES_W-1:0]    r_ores;
    logic                r_ostat;

    logic                m_we;
    logic [AW-1:0]       m_waddr, m_raddr;
    logic [7:0]          m_wdata, m_rdata;

    logic [SIZE_W-1:0]   size_use;
    logic [SIZE_W-1:0]   ofs;
    logic                past_end;
    logic                hit;
    logic [2:0]          sh;
    logic [6:0]          widx;
    logic                wbit, rbit;
    logic [CURSOR_W-1:0] cur_inc;
    logic [CURSOR_W-1:0] start_sum;
    logic                in_fire, out_fire, cfg_wr;
    logic [RES_W-1:0]    half;

    ebb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    // handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_ovalid && i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_result_value = r_ores;
    assign o_status       = r_ostat;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_W'(4096);
            r_start <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_BUFFER_SIZE: r_size  <= pwdata[SIZE_W-1:0];
                REG_START_BIT:   r_start <= pwdata[START_W-1:0];
                default:         r_size  <= r_size;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BUFFER_SIZE: prdata = {{(32-SIZE_W){1'b0}}, r_size};
            REG_START_BIT:   prdata = {{(32-START_W){1'b0}}, r_start};
            default:         prdata = '0;
        endcase
    end

    // cursor helpers
    assign size_use  = (r_size < SIZE_MAX) ? r_size : SIZE_MAX;
    assign ofs       = r_cursor[CURSOR_W-1:3];
    assign past_end  = (ofs >= size_use);
    assign hit       = r_cok && (r_caddr == ofs[AW-1:0]);
    assign sh        = ~r_cursor[2:0];
    assign widx      = r_left - 7'd1;
    assign wbit      = (widx < 7'd33) ? r_wdata[widx[5:0]] : 1'b0;
    assign rbit      = r_cache[sh];
    assign cur_inc   = (r_cursor == '1) ? r_cursor : r_cursor + 16'd1;
    assign start_sum = {1'b0, r_start} + 16'd7;
    assign half      = {1'b0, r_acc[RES_W-1:1]};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_cursor = r_cursor;
        n_left   = r_left;
        n_wdata  = r_wdata;
        n_acc    = r_acc;
        n_zeros  = r_zeros;
        n_cache  = r_cache;
        n_caddr  = r_caddr;
        n_cok    = r_cok;
        n_dirty  = r_dirty;
        n_res    = r_res;
        n_err    = r_err;
        m_we     = 1'b0;
        m_waddr  = r_caddr;
        m_wdata  = r_cache;
        m_raddr  = ofs[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_kind  = t_cmd'(i_cmd);
                    n_res   = '0;
                    n_err   = 1'b0;
                    n_cok   = 1'b0;
                    n_dirty = 1'b0;
                    n_zeros = '0;
                    n_acc   = '0;
                    n_state = S_FIN;
                    unique case (i_cmd)
                        CMD_RESTART: begin
                            if (start_sum[CURSOR_W-1:3] >= size_use) n_err = 1'b1;
                            else n_cursor = {1'b0, r_start};
                        end
                        CMD_LOAD: begin
                            if ({1'b0, i_addr} >= size_use) begin
                                n_err = 1'b1;
                            end else begin
                                m_we    = 1'b1;
                                m_waddr = i_addr[AW-1:0];
                                m_wdata = i_value[7:0];
                            end
                        end
                        CMD_RD_BYTE: begin
                            if ({1'b0, i_addr} >= size_use) begin
                                n_err = 1'b1;
                            end else begin
                                m_raddr = i_addr[AW-1:0];
                                n_state = S_RDB;
                            end
                        end
                        CMD_WR_BITS, CMD_RD_BITS: begin
                            if (i_count > 6'(MAX_FIELD_BITS)) begin
                                n_err = 1'b1;
                            end else begin
                                n_left  = {1'b0, i_count};
                                n_wdata = {1'b0, i_value};
                                n_phase = (i_cmd == CMD_WR_BITS) ? PH_WR : PH_RD;
                                n_state = S_BIT;
                            end
                        end
                        CMD_WR_FLAG: begin
                            n_left  = 7'd1;
                            n_wdata = {32'd0, (i_value != 32'd0)};
                            n_phase = PH_WR;
                            n_state = S_BIT;
                        end
                        CMD_WR_UE: begin
                            n_wdata = {1'b0, i_value} + 33'd1;
                            n_acc   = {1'b0, i_value} + 33'd1;
                            n_left  = 7'd32;
                            n_state = S_LZ;
                        end
                        CMD_RD_UE, CMD_RD_SE: begin
                            n_phase = PH_PRE;
                            n_state = S_BIT;
                        end
                        default: n_err = 1'b1;
                    endcase
                end
            end
            // leading zero scan of the ue code, one bit per cycle
            S_LZ: begin
                if (r_acc[RES_W-1]) begin
                    n_left  = {r_left[5:0], 1'b1};
                    n_phase = PH_WR;
                    n_state = S_BIT;
                end else begin
                    n_acc  = {r_acc[RES_W-2:0], 1'b0};
                    n_left = r_left - 7'd1;
                end
            end
            S_RDB: begin
                n_res   = {25'd0, m_rdata};
                n_state = S_FIN;
            end
            // one bit per cycle on the cached byte
            S_BIT: begin
                if (r_phase != PH_PRE && r_left == 7'd0) begin
                    n_state = S_FIN;
                    unique case (r_kind)
                        CMD_RD_BITS: n_res = r_acc;
                        CMD_RD_UE:   n_res = r_acc - 33'd1;
                        CMD_RD_SE:   n_res = r_acc[0] ? (33'd0 - half) : half;
                        default:     n_res = '0;
                    endcase
                end else if (past_end) begin
                    n_cursor = cur_inc;
                    n_err    = 1'b1;
                    n_state  = S_FIN;
                end else if (hit) begin
                    n_cursor = cur_inc;
                    unique case (r_phase)
                        PH_WR: begin
                            n_cache[sh] = wbit;
                            n_dirty     = 1'b1;
                            n_left      = r_left - 7'd1;
                        end
                        PH_RD: begin
                            n_acc  = {r_acc[RES_W-2:0], rbit};
                            n_left = r_left - 7'd1;
                        end
                        PH_PRE: begin
                            if (rbit) begin
                                n_phase = PH_RD;
                                n_left  = {2'd0, r_zeros};
                                n_acc   = 33'd1;
                            end else if (r_zeros == 5'd31) begin
                                n_err   = 1'b1;
                                n_state = S_FIN;
                            end else begin
                                n_zeros = r_zeros + 5'd1;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end else begin
                    // miss: write back the old byte, fetch the new one
                    m_we    = r_dirty;
                    n_dirty = 1'b0;
                    n_caddr = ofs[AW-1:0];
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_cache = m_rdata;
                n_cok   = 1'b1;
                n_state = S_BIT;
            end
            S_FIN: begin
                m_we    = r_dirty;
                n_dirty = 1'b0;
                if (!r_ovalid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_cok    <= 1'b0;
            r_dirty  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_cok    <= n_cok;
            r_dirty  <= n_dirty;
            if (r_state == S_FIN && (!r_ovalid || i_out_ready)) r_ovalid <= 1'b1;
            else if (out_fire) r_ovalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_kind  <= n_kind;
        r_left  <= n_left;
        r_wdata <= n_wdata;
        r_acc   <= n_acc;
        r_zeros <= n_zeros;
        r_cache <= n_cache;
        r_caddr <= n_caddr;
        r_res   <= n_res;
        r_err   <= n_err;
        if (r_state == S_FIN && (!r_ovalid || i_out_ready)) begin
            r_ores  <= r_err ? '0 : r_res;
            r_ostat <= r_err;
        end
    end

    // checks
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_dirty)
        else $error("dirty cache byte left after request");
    a_fetch_from_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> ($past(r_state) == S_BIT))
        else $error("fetch without miss");
    a_cursor_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |=> (r_cursor == $past(r_cursor) ||
                                r_cursor == $past(r_cursor) + 16'd1))
        else $error("cursor moved more than one bit");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat) |-> (r_ores == '0))
        else $error("nonzero result on error");

endmodule
`default_nettype wire

// File: tb/sv/tb_exp_golomb_bit_buffer_core.sv
`timescale 1ns / 100ps

module tb_exp_golomb_bit_buffer_core;
    import ebb_pkg::*;

    localparam int NUM_BYTES = BUFFER_BYTES_DEF;
    localparam logic [3:0] CMD_BAD_FIRST = 4'd9;
    localparam logic [3:0] CMD_BAD_LAST  = 4'd15;
    localparam logic [15:0] CURSOR_SAT  = 16'hFFFF;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             status;
    } t_result;

    // DUT signals
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [3:0]                  i_cmd = '0;
    logic [11:0]                 i_addr = '0;
    logic [5:0]                  i_count = '0;
    logic [31:0]                 i_value = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [RES_W-1:0]     o_result_value;
    logic                        o_status;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [PADDR_W-1:0]          paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // buffer shadow and pending results
    logic [7:0]        shadow_mem [NUM_BYTES];
    bit                byte_loaded [NUM_BYTES];
    logic [15:0]       shadow_cursor;
    logic [SIZE_W-1:0] shadow_size;
    logic [START_W-1:0] shadow_start;
    t_result           pending_results [$];

    int  error_count;
    int  items_sent;
    int  stall_left;
    bit  quiet_mode;

    exp_golomb_bit_buffer_core u_top (.*);

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    //--------------------------------------------------------------------
    // bit buffer predictor
    //--------------------------------------------------------------------
    function automatic int size_limit();
        return (shadow_size < NUM_BYTES) ? int'(shadow_size) : NUM_BYTES;
    endfunction

    // one bit at the cursor; 0 when the bit lies past the buffer end
    function automatic bit access_bit(input bit wr, input bit bin, output bit bout);
        int pos;
        int ofs;
        int sh;
        pos = shadow_cursor;
        ofs = pos >> 3;
        sh  = 7 - (pos & 7);
        bout = 1'b0;
        shadow_cursor = (shadow_cursor < CURSOR_SAT) ? shadow_cursor + 16'd1 : CURSOR_SAT;
        if (ofs >= size_limit())
            return 1'b0;
        if (wr)
            shadow_mem[ofs][sh] = bin;
        else
            bout = shadow_mem[ofs][sh];
        return 1'b1;
    endfunction

    function automatic bit put_field(input int n, input logic [63:0] v);
        bit dummy;
        for (int i = n - 1; i >= 0; i--) begin
            if (!access_bit(1'b1, v[i], dummy))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit get_field(input int n, output logic [63:0] v);
        bit b;
        v = '0;
        for (int i = 0; i < n; i++) begin
            if (!access_bit(1'b0, 1'b0, b))
                return 1'b0;
            v = {v[62:0], b};
        end
        return 1'b1;
    endfunction

    function automatic bit get_golomb(output logic [63:0] v);
        int zeros;
        bit b;
        logic [63:0] tail;
        zeros = 0;
        v = '0;
        forever begin
            if (!access_bit(1'b0, 1'b0, b))
                return 1'b0;
            if (b)
                break;
            zeros++;
            if (zeros > 31)
                return 1'b0;
        end
        if (!get_field(zeros, tail))
            return 1'b0;
        v = ((64'd1 << zeros) - 64'd1) + tail;
        return 1'b1;
    endfunction

    function automatic t_result bitbuf_predict(input logic [3:0] cmd, input logic [11:0] addr,
                                               input logic [5:0] count, input logic [31:0] value);
        t_result r;
        logic [63:0] t;
        logic [63:0] code;
        int lz;
        bit ok;
        bit dummy;
        r = '0;
        t = '0;
        ok = 1'b1;
        case (cmd)
            CMD_RESTART: begin
                if (((int'(shadow_start) + 7) >> 3) >= size_limit())
                    ok = 1'b0;
                else
                    shadow_cursor = 16'(shadow_start);
            end
            CMD_LOAD: begin
                if (addr >= size_limit())
                    ok = 1'b0;
                else begin
                    shadow_mem[addr] = value[7:0];
                    byte_loaded[addr] = 1'b1;
                end
            end
            CMD_RD_BYTE: begin
                if (addr >= size_limit())
                    ok = 1'b0;
                else
                    r.value = RES_W'(shadow_mem[addr]);
            end
            CMD_WR_BITS: ok = (count <= MAX_FIELD_BITS) && put_field(count, 64'(value));
            CMD_WR_FLAG: ok = access_bit(1'b1, value != 0, dummy);
            CMD_WR_UE: begin
                code = 64'(value) + 64'd1;
                lz = 0;
                while ((code >> (lz + 1)) != 0)
                    lz++;
                ok = put_field(lz, 64'd0) && put_field(lz + 1, code);
            end
            CMD_RD_BITS: begin
                ok = (count <= MAX_FIELD_BITS) && get_field(count, t);
                if (ok)
                    r.value = t[RES_W-1:0];
            end
            CMD_RD_UE: begin
                ok = get_golomb(t);
                if (ok)
                    r.value = t[RES_W-1:0];
            end
            CMD_RD_SE: begin
                ok = get_golomb(t);
                if (ok)
                    r.value = t[0] ? RES_W'((t + 64'd1) >> 1) : RES_W'(64'd0 - (t >> 1));
            end
            default: ok = 1'b0;
        endcase
        if (!ok)
            r.value = '0;
        r.status = !ok;
        return r;
    endfunction

    //--------------------------------------------------------------------
    // mismatch reporting and result checking
    //--------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result_value !== exp_r.value)
                    report_mismatch($sformatf("result_value got %h expected %h",
                                              o_result_value, exp_r.value));
                if (o_status !== exp_r.status)
                    report_mismatch($sformatf("status got %b expected %b",
                                              o_status, exp_r.status));
            end
        end
    end

    // receiver: random ready with occasional random stalls, forced stalls when requested
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (quiet_mode) begin
            i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 2) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(8, 40);
        end else begin
            i_out_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    //--------------------------------------------------------------------
    // stimulus helpers
    //--------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request and predict it when accepted
    task automatic send_req(input logic [3:0] cmd, input logic [11:0] addr,
                            input logic [5:0] count, input logic [31:0] value);
        int gap;
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_addr     <= addr;
        i_count    <= count;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(bitbuf_predict(cmd, addr, count, value));
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // never let the block see a byte that was not loaded
    task automatic load_window(input logic [3:0] cmd, input logic [11:0] addr);
        int lo;
        int hi;
        if (cmd == CMD_RD_BYTE) begin
            lo = addr;
            hi = addr;
        end else if (cmd >= CMD_RD_BYTE && cmd <= CMD_RD_SE) begin
            lo = shadow_cursor >> 3;
            hi = (int'(shadow_cursor) + 72) >> 3;
        end else begin
            return;
        end
        if (hi >= size_limit())
            hi = size_limit() - 1;
        for (int a = lo; a <= hi; a++) begin
            if (!byte_loaded[a])
                send_req(CMD_LOAD, 12'(a), 6'($urandom), $urandom);
        end
    endtask

    task automatic issue(input logic [3:0] cmd, input logic [11:0] addr,
                         input logic [5:0] count, input logic [31:0] value);
        load_window(cmd, addr);
        send_req(cmd, addr, count, value);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic set_config(input logic [SIZE_W-1:0] size, input logic [START_W-1:0] start);
        wait_drained();
        apb_write(PADDR_W'(REG_BUFFER_SIZE) << 2, 32'(size));
        shadow_size = size;
        apb_write(PADDR_W'(REG_START_BIT) << 2, 32'(start));
        shadow_start = start;
    endtask

    function automatic logic [31:0] rand_ue();
        if ($urandom_range(0, 19) == 0)
            return 32'hFFFF_FFFF;
        return $urandom >> $urandom_range(0, 31);
    endfunction

    //--------------------------------------------------------------------
    // tests
    //--------------------------------------------------------------------
    task automatic test_directed();
        // defaults after reset: full buffer, start at bit 0
        issue(CMD_RESTART, 0, 0, 0);
        issue(CMD_WR_BITS, 0, 6'd32, 32'hFFFF_FFFF);
        issue(CMD_WR_BITS, 0, 6'd0, 32'h1234_5678);
        issue(CMD_WR_BITS, 0, 6'd63, 32'hFFFF_FFFF);
        issue(CMD_WR_FLAG, 0, 0, 32'd0);
        issue(CMD_WR_FLAG, 0, 0, 32'h8000_0000);
        issue(CMD_WR_UE, 0, 0, 32'd0);
        issue(CMD_WR_UE, 0, 0, 32'hFFFF_FFFF);
        issue(CMD_WR_UE, 0, 0, 32'd4);
        issue(CMD_RESTART, 0, 0, 0);
        issue(CMD_RD_BITS, 0, 6'd32, 0);
        issue(CMD_RD_BITS, 0, 6'd0, 0);
        issue(CMD_RD_BITS, 0, 6'd40, 0);
        issue(CMD_RD_BITS, 0, 6'd2, 0);
        issue(CMD_RD_UE, 0, 0, 0);
        issue(CMD_RD_UE, 0, 0, 0);
        issue(CMD_RD_SE, 0, 0, 0);
        issue(CMD_BAD_FIRST, 12'hFFF, 6'h3F, 32'hFFFF_FFFF);
        issue(CMD_BAD_LAST, 0, 0, 0);
        issue(CMD_LOAD, 12'hFFF, 0, 32'h0000_00A5);
        issue(CMD_RD_BYTE, 12'hFFF, 0, 0);
        // long zero prefix and negative se in a tiny buffer
        set_config(13'd8, 15'd0);
        for (int a = 0; a < 8; a++)
            issue(CMD_LOAD, 12'(a), 0, 32'd0);
        issue(CMD_RESTART, 0, 0, 0);
        issue(CMD_RD_UE, 0, 0, 0);
        issue(CMD_RESTART, 0, 0, 0);
        issue(CMD_WR_UE, 0, 0, 32'd4);
        issue(CMD_RESTART, 0, 0, 0);
        issue(CMD_RD_SE, 0, 0, 0);
        // bits past the end, bad address, bad restart
        issue(CMD_WR_BITS, 0, 6'd32, $urandom);
        issue(CMD_WR_BITS, 0, 6'd32, $urandom);
        issue(CMD_LOAD, 12'd8, 0, 32'd1);
        issue(CMD_RD_BYTE, 12'd8, 0, 0);
        set_config(13'd8, 15'd57);
        issue(CMD_RESTART, 0, 0, 0);
    endtask

    // write one to six fields, rewind, read them back; ue fields are read as ue or se
    task automatic run_sequence();
        logic [3:0] kinds [6];
        logic [5:0] lens [6];
        int n;
        n = $urandom_range(1, 6);
        issue(CMD_RESTART, 0, 0, 0);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
                0: kinds[i] = CMD_WR_BITS;
                1: kinds[i] = CMD_WR_FLAG;
                default: kinds[i] = CMD_WR_UE;
            endcase
            lens[i] = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
            issue(kinds[i], 0, lens[i],
                  (kinds[i] == CMD_WR_UE) ? rand_ue() : $urandom);
        end
        issue(CMD_RESTART, 0, 0, 0);
        for (int i = 0; i < n; i++) begin
            case (kinds[i])
                CMD_WR_BITS: issue(CMD_RD_BITS, 0, lens[i], $urandom);
                CMD_WR_FLAG: issue(CMD_RD_BITS, 0, 6'd1, $urandom);
                default: issue($urandom_range(0, 1) ? CMD_RD_UE : CMD_RD_SE, 0, 0, $urandom);
            endcase
        end
    endtask

    task automatic run_noise();
        logic [3:0] cmd;
        logic [11:0] addr;
        cmd = 4'($urandom);
        if ($urandom_range(0, 1) && size_limit() > 0)
            addr = 12'($urandom_range(0, size_limit() - 1));
        else
            addr = 12'($urandom);
        // byte reads only from loaded bytes or out of range
        if (cmd == CMD_RD_BYTE && addr < size_limit() && !byte_loaded[addr])
            cmd = CMD_LOAD;
        issue(cmd, addr, 6'($urandom), $urandom);
    endtask

    task automatic pick_config();
        int r;
        logic [SIZE_W-1:0] size;
        r = $urandom_range(0, 9);
        if (r == 0)
            size = 13'h1FFF;
        else if (r == 1)
            size = 13'd4096;
        else if (r == 2)
            size = 13'd0;
        else if (r == 3)
            size = 13'd1;
        else
            size = 13'($urandom_range(2, 32));
        if ($urandom_range(0, 5) == 0)
            set_config(size, 15'h7FFF);
        else if (size > 4 && size <= 32)
            set_config(size, 15'($urandom_range(0, size * 8)));
        else
            set_config(size, 15'($urandom_range(0, 1) ? 0 : $urandom_range(0, 63)));
    endtask

    task automatic test_random();
        int phase_start;
        while (items_sent < 750) begin
            pick_config();
            quiet_mode = ($urandom_range(0, 4) == 0);
            phase_start = items_sent;
            while (items_sent - phase_start < 90 && items_sent < 750) begin
                if ($urandom_range(0, 4) == 0)
                    run_noise();
                else
                    run_sequence();
            end
        end
        quiet_mode = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        set_config(13'd32, 15'd0);
        quiet_mode = 1'b1;
        // off the rising edge so the receiver process picks it up cleanly
        @(negedge i_clk);
        stall_left = 300;
        @(posedge i_clk);
        for (int i = 0; i < 24; i++)
            run_noise();
        quiet_mode = 1'b0;
        wait_drained();
        run_sequence();
    endtask

    //--------------------------------------------------------------------
    // main
    //--------------------------------------------------------------------
    initial begin
        error_count   = 0;
        items_sent    = 0;
        stall_left    = 0;
        quiet_mode    = 1'b0;
        shadow_cursor = '0;
        shadow_size   = 13'd4096;
        shadow_start  = '0;
        foreach (shadow_mem[a]) begin
            shadow_mem[a]  = '0;
            byte_loaded[a] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
